### rtl/aqhcm_pkg.sv
// ============================================================================
// aqhcm_pkg
// Shared types, constants and the colour rule for the air-quality mapper.
// ============================================================================
`default_nettype none
package aqhcm_pkg;

  localparam int unsigned HistoryDepthDef = 8;
  localparam int unsigned RecentDepthDef  = 3;
  localparam int unsigned IaqW  = 9;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SumW  = 17;
  localparam int unsigned CntW  = 8;
  localparam int unsigned HueW  = 16;

  localparam logic [0:0] RegIntervalMs  = 1'b0;
  localparam logic [0:0] RegMinAccuracy = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT_DIV,
    ST_UPDATE,
    ST_AVG_DIV,
    ST_RECENT_DIV,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture input item and start slot division
    logic div_step;   // one step of the shared divider
    logic update;     // accumulate and decide shift
    logic start_avg;  // start interval average division
    logic start_rec;  // start recent average division
    logic emit_load;  // load output register with pixel at emit index
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic avg_needed;
    logic emit_last;
  } status_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [7:0]      sat;
    logic [7:0]      bri;
  } colour_t;

  function automatic colour_t map_colour(input logic [IaqW-1:0] v);
    colour_t c;
    logic [HueW-1:0] prod;
    c.sat = 8'd255;
    c.bri = 8'd255;
    prod  = '0;
    if (v < 9'd50) begin
      c.hue = 16'd21845;
      c.bri = 8'(8'd105 + 8'(v) * 8'd3);
    end else if (v < 9'd100) begin
      c.hue = 16'(16'd21845 - (16'(v) - 16'd50));
    end else if (v < 9'd250) begin
      prod  = 16'((16'(v) - 16'd100) * 16'd109);
      c.hue = 16'(16'd10922 - prod);
    end else if (v < 9'd350) begin
      prod  = 16'((16'(v) - 16'd150) * 16'd55);
      c.hue = 16'(16'd60074 - prod);
    end else begin
      c.hue = 16'd3640;
      c.sat = 8'd192;
      c.bri = 8'd92;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/aqhcm_ctrl.sv
// ============================================================================
// aqhcm_ctrl
// Sequencer: slot division, update, average divisions, pixel emission.
// ============================================================================
`default_nettype none
module aqhcm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic               out_free,
  input  wire aqhcm_pkg::status_t sts,
  output aqhcm_pkg::cmd_t         cmd,
  output logic                    busy
);
  import aqhcm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_fire) state_next = ST_SLOT_DIV;
      ST_SLOT_DIV:   if (sts.div_done) state_next = ST_UPDATE;
      ST_UPDATE:     state_next = sts.avg_needed ? ST_AVG_DIV : ST_RECENT_DIV;
      ST_AVG_DIV:    if (sts.div_done) state_next = ST_RECENT_DIV;
      ST_RECENT_DIV: if (sts.div_done) state_next = ST_EMIT;
      ST_EMIT:       if (out_free && sts.emit_last) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE:       cmd.load = in_fire;
      ST_SLOT_DIV:   cmd.div_step = !sts.div_done;
      ST_UPDATE: begin
        cmd.update    = 1'b1;
        cmd.start_avg = sts.avg_needed;
        cmd.start_rec = !sts.avg_needed;
      end
      ST_AVG_DIV: begin
        cmd.div_step  = !sts.div_done;
        cmd.start_rec = sts.div_done;
      end
      ST_RECENT_DIV: cmd.div_step = !sts.div_done;
      ST_EMIT:       cmd.emit_load = out_free;
      default:       cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/aqhcm_datapath.sv
// ============================================================================
// aqhcm_datapath
// Interval state, history shift line, shared restoring divider, pixel output.
// ============================================================================
`default_nettype none
module aqhcm_datapath #(
  parameter int unsigned HISTORY_DEPTH = aqhcm_pkg::HistoryDepthDef,
  parameter int unsigned RECENT_DEPTH  = aqhcm_pkg::RecentDepthDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire aqhcm_pkg::cmd_t               cmd,
  output aqhcm_pkg::status_t                 sts,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_idx,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic [aqhcm_pkg::IaqW-1:0]    in_iaq,
  input  wire logic [1:0]                    in_acc,
  input  wire logic [aqhcm_pkg::TimeW-1:0]   in_time,
  output logic [2:0]                         px_index,
  output aqhcm_pkg::colour_t                 px_colour,
  output logic                               px_last
);
  import aqhcm_pkg::*;

  localparam int unsigned HIdxW = $clog2(HISTORY_DEPTH);
  localparam int unsigned RSumW = IaqW + $clog2(RECENT_DEPTH + 1);
  localparam int unsigned DivW  = 32;
  localparam int unsigned StepW = $clog2(DivW + 1);

  logic [31:0]       interval_ms;
  logic [1:0]        min_accuracy;
  logic [SumW-1:0]   interval_sum;
  logic [CntW-1:0]   sample_count;
  logic [TimeW-1:0]  interval_number;
  logic [IaqW-1:0]   history [HISTORY_DEPTH];
  logic [IaqW-1:0]   recent  [RECENT_DEPTH];
  logic [IaqW-1:0]   iaq_r;
  logic [1:0]        acc_r;
  logic              shifted;
  logic [IaqW-1:0]   recent_avg;
  logic [HIdxW-1:0]  emit_idx;

  // Shared restoring divider, one quotient bit per cycle.
  logic [DivW-1:0]   dv_num, dv_den, dv_quo;
  logic [DivW:0]     dv_rem;
  logic [StepW-1:0]  dv_cnt;
  logic [DivW:0]     dv_trial;
  logic [DivW:0]     dv_shift;

  logic              add_ok;
  logic [SumW-1:0]   sum_acc;
  logic [CntW-1:0]   cnt_acc;
  logic              do_shift;
  logic [RSumW-1:0]  rec_total;

  assign dv_shift = {dv_rem[DivW-1:0], dv_num[DivW-1]};
  assign dv_trial = dv_shift - {1'b0, dv_den};
  assign sts.div_done = (dv_cnt == StepW'(DivW));

  assign add_ok  = (acc_r >= min_accuracy) && (sample_count != 8'd255);
  assign sum_acc = add_ok ? SumW'(interval_sum + SumW'(iaq_r)) : interval_sum;
  assign cnt_acc = add_ok ? CntW'(sample_count + 8'd1) : sample_count;
  assign do_shift = (dv_quo > interval_number);
  assign sts.avg_needed = !do_shift && (cnt_acc != '0);
  assign sts.emit_last = shifted ? (emit_idx == HIdxW'(HISTORY_DEPTH - 1))
                                 : (emit_idx == '0);

  always_comb begin
    rec_total = '0;
    for (int i = 0; i < int'(RECENT_DEPTH); i++) begin
      rec_total = RSumW'(rec_total + RSumW'(recent[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms     <= 32'd300000;
      min_accuracy    <= 2'd2;
      interval_sum    <= '0;
      sample_count    <= '0;
      interval_number <= '0;
      for (int i = 0; i < int'(HISTORY_DEPTH); i++) history[i] <= '0;
      for (int i = 0; i < int'(RECENT_DEPTH); i++) recent[i] <= '0;
      dv_cnt          <= '0;
      shifted         <= 1'b0;
      emit_idx        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == RegIntervalMs) interval_ms <= cfg_data;
        else min_accuracy <= cfg_data[1:0];
      end
      if (cmd.load) begin
        iaq_r  <= in_iaq;
        acc_r  <= in_acc;
        dv_num <= in_time;
        dv_den <= (interval_ms == '0) ? 32'd1 : interval_ms;
        dv_rem <= '0;
        dv_cnt <= '0;
        emit_idx <= '0;
        for (int i = RECENT_DEPTH - 1; i > 0; i--) recent[i] <= recent[i-1];
        recent[0] <= in_iaq;
      end
      if (cmd.div_step) begin
        dv_num <= {dv_num[DivW-2:0], 1'b0};
        if (!dv_trial[DivW]) begin
          dv_rem <= dv_trial;
          dv_quo <= {dv_quo[DivW-2:0], 1'b1};
        end else begin
          dv_rem <= dv_shift;
          dv_quo <= {dv_quo[DivW-2:0], 1'b0};
        end
        dv_cnt <= StepW'(dv_cnt + 1'b1);
      end
      if (cmd.update) begin
        shifted <= do_shift;
        if (do_shift) begin
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) history[i] <= history[i-1];
          history[0]      <= '0;
          interval_number <= dv_quo;
          interval_sum    <= '0;
          sample_count    <= '0;
        end else begin
          interval_sum <= sum_acc;
          sample_count <= cnt_acc;
        end
      end
      if (cmd.start_avg) begin
        dv_num <= DivW'(sum_acc) << (DivW - SumW);
        dv_den <= DivW'(cnt_acc);
        dv_rem <= '0;
        dv_cnt <= StepW'(DivW - SumW);
      end
      if (cmd.start_rec) begin
        if (cmd.div_step == 1'b0 && !cmd.update) begin
          history[0] <= IaqW'(dv_quo);
        end else if (cmd.div_step) begin
          history[0] <= IaqW'({dv_quo[DivW-2:0], !dv_trial[DivW]});
        end
        dv_num <= DivW'(rec_total) << (DivW - RSumW);
        dv_den <= DivW'(RECENT_DEPTH);
        dv_rem <= '0;
        dv_cnt <= StepW'(DivW - RSumW);
      end
      if (cmd.emit_load) begin
        emit_idx <= HIdxW'(emit_idx + 1'b1);
      end
    end
  end

  // Output register: pixel 0 from the recent average, others from history.
  assign recent_avg = IaqW'(dv_quo);
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      px_index  <= 3'(emit_idx);
      px_colour <= map_colour((emit_idx == '0) ? recent_avg : history[emit_idx]);
      px_last   <= sts.emit_last;
    end
  end

endmodule
`default_nettype wire

### rtl/air_quality_history_colour_mapper.sv
// ============================================================================
// air_quality_history_colour_mapper
// Averages air-quality readings per interval and maps them to pixel colours.
// ============================================================================
// Channel  Dir  Contents
// s_axis   in   tdata: iaq_value[8:0], accuracy[10:9], time_ms[42:11]
// m_axis   out  tdata: pixel_index[2:0], hue[18:3], saturation[26:19],
//               brightness[34:27]; tlast: last
// cfg      in   index 0 interval_ms, index 1 min_accuracy
//
// One item at a time. The shared one-bit-per-cycle divider runs 32 steps for
// the time slot, then the update, 17 steps for the interval average when it is
// needed and 11 for the three-sample average, then one pixel per cycle (1 or 8)
// while the output is free. The block stays busy until the last pixel is
// loaded; output stalls in the pixel phase keep it busy longer.
// Reset is synchronous; all but the input, operand and pixel registers reset.
// ============================================================================
`default_nettype none
module air_quality_history_colour_mapper #(
  parameter int unsigned HISTORY_DEPTH = aqhcm_pkg::HistoryDepthDef,
  parameter int unsigned RECENT_DEPTH  = aqhcm_pkg::RecentDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // iaq_value, accuracy, time_ms
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // pixel_index, hue, saturation, brightness
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import aqhcm_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    busy;
  logic    in_fire;
  logic    out_free;
  logic [2:0] px_index;
  colour_t px_colour;
  logic    px_last;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {5'd0, px_colour.bri, px_colour.sat, px_colour.hue, px_index};
  assign m_axis_tlast = px_last;

  aqhcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  aqhcm_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .RECENT_DEPTH  (RECENT_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_index),
    .cfg_data  (cfg_data),
    .in_iaq    (s_axis_tdata[8:0]),
    .in_acc    (s_axis_tdata[10:9]),
    .in_time   (s_axis_tdata[42:11]),
    .px_index  (px_index),
    .px_colour (px_colour),
    .px_last   (px_last)
  );

endmodule
`default_nettype wire

### dv/tb_air_quality_history_colour_mapper.sv
// ----------------------------------------------------------------------------
// Testbench for air_quality_history_colour_mapper
// Drives readings over the input stream with random gaps, predicts the pixel
// colours of every reading and compares each output item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_air_quality_history_colour_mapper;
  import aqhcm_pkg::*;

  typedef struct packed {
    logic [2:0]  pixel;
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  bri;
    logic        last;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // iaq_value[8:0], accuracy[10:9], time_ms[42:11]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // pixel_index[2:0], hue[18:3], saturation[26:19],
                               // brightness[34:27]
  logic        m_axis_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  air_quality_history_colour_mapper i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted machine state.
  logic [31:0] interval_len;
  logic [1:0]  accuracy_floor;
  logic [16:0] sum_acc;
  logic [7:0]  sample_cnt;
  logic [31:0] slot_num;
  logic [8:0]  hist [8];
  logic [8:0]  recent [3];

  pixel_t pixel_queue[$];
  int     errors = 0;
  int     cycles = 0;
  int     rx_wait;
  logic   rx_ready_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic pixel_t colour_of(logic [8:0] v, logic [2:0] idx, logic lst);
    pixel_t p;
    int unsigned vi;
    vi     = v;
    p.pixel = idx;
    p.last  = lst;
    p.sat   = 8'd255;
    p.bri   = 8'd255;
    if (vi < 50) begin
      p.hue = 16'd21845;
      p.bri = 8'(105 + 3 * vi);
    end else if (vi < 100) begin
      p.hue = 16'(21845 - (vi - 50));
    end else if (vi < 250) begin
      p.hue = 16'(10922 - (vi - 100) * 109);
    end else if (vi < 350) begin
      p.hue = 16'(60074 - (vi - 150) * 55);
    end else begin
      p.hue = 16'd3640;
      p.sat = 8'd192;
      p.bri = 8'd92;
    end
    return p;
  endfunction

  task automatic predict_pixels(logic [8:0] iaq, logic [1:0] acc, logic [31:0] t);
    logic [31:0] slot;
    logic        shifted;
    int unsigned total;
    slot    = t / ((interval_len == 0) ? 32'd1 : interval_len);
    shifted = 1'b0;
    if (acc >= accuracy_floor && sample_cnt < 8'd255) begin
      sample_cnt = sample_cnt + 8'd1;
      sum_acc    = sum_acc + 17'(iaq);
    end
    if (slot > slot_num) begin
      for (int i = 7; i > 0; i--) hist[i] = hist[i-1];
      slot_num   = slot;
      sum_acc    = '0;
      sample_cnt = '0;
      hist[0]    = '0;
      shifted    = 1'b1;
    end
    if (sample_cnt != 0) hist[0] = 9'(sum_acc / sample_cnt);
    recent[2] = recent[1];
    recent[1] = recent[0];
    recent[0] = iaq;
    total = recent[0] + recent[1] + recent[2];
    pixel_queue.push_back(colour_of(9'(total / 3), 3'd0, !shifted));
    if (shifted) begin
      for (int i = 1; i < 8; i++) pixel_queue.push_back(colour_of(hist[i], 3'(i), i == 7));
    end
  endtask

  // Output side: a random wait before each item, and field checks.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        pixel_t got, want;
        got = {m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tdata[26:19],
               m_axis_tdata[34:27], m_axis_tlast};
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected item %h", $time, got);
          errors++;
        end else begin
          want = pixel_queue.pop_front();
          if (got.pixel !== want.pixel) begin
            $display("%0t: pixel_index exp %0d got %0d", $time, want.pixel, got.pixel);
            errors++;
          end
          if (got.hue !== want.hue) begin
            $display("%0t: hue exp %0d got %0d", $time, want.hue, got.hue);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturation exp %0d got %0d", $time, want.sat, got.sat);
            errors++;
          end
          if (got.bri !== want.bri) begin
            $display("%0t: brightness exp %0d got %0d", $time, want.bri, got.bri);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
            errors++;
          end
        end
        rx_wait = $urandom_range(0, 4);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      // Some stretches run with no stalls at all.
      m_axis_tready <= rx_ready_hold || (rx_wait == 0);
    end
  end

  // The valid stays high from one item to the next when no gap is drawn.
  task automatic send_reading(logic [8:0] iaq, logic [1:0] acc, logic [31:0] t);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, t, acc, iaq};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_pixels(iaq, acc, t);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegIntervalMs) interval_len = val;
    else accuracy_floor = val[1:0];
  endtask

  // Extremes of each field and every colour band.
  task automatic test_directed();
    logic [31:0] t;
    logic [8:0]  vals [12];
    vals = '{0, 49, 50, 99, 100, 249, 250, 349, 350, 500, 511, 255};
    t = 0;
    foreach (vals[i]) begin
      send_reading(vals[i], 2'(i), t);
      t = t + 400;
    end
    send_reading(9'd300, 2'd3, 32'hFFFF_FFFF);
    send_reading(9'd511, 2'd3, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Fill the count to saturation in one long interval.
  task automatic test_count_saturation();
    write_reg(RegIntervalMs, 32'hFFFF_FFFF);
    write_reg(RegMinAccuracy, 32'd0);
    for (int i = 0; i < 258; i++) send_reading(9'($urandom_range(0, 511)), 2'($urandom), 32'd5);
    wait_drained();
  endtask

  // Random readings with mostly increasing time, so shifts happen often.
  task automatic test_random(int n, logic [31:0] ilen, logic [1:0] floor_val);
    logic [31:0] t;
    write_reg(RegIntervalMs, ilen);
    write_reg(RegMinAccuracy, 32'(floor_val));
    t = slot_num * ((ilen == 0) ? 32'd1 : ilen);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: t = $urandom;
        1, 2, 3: t = t + $urandom_range(0, 3) * ((ilen == 0) ? 1 : ilen);
        default: t = t + $urandom_range(0, 7);
      endcase
      rx_ready_hold = ($urandom_range(0, 5) == 0);
      send_reading(($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 500)),
                   2'($urandom), t);
      if (i == n / 2) wait_drained();
    end
    rx_ready_hold = 1'b0;
    wait_drained();
  endtask

  initial begin
    rx_ready_hold  = 1'b0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_we         = 1'b0;
    cfg_index      = 1'b0;
    cfg_data       = '0;
    interval_len   = 32'd300000;
    accuracy_floor = 2'd2;
    sum_acc        = '0;
    sample_cnt     = '0;
    slot_num       = '0;
    foreach (hist[i]) hist[i] = '0;
    foreach (recent[i]) recent[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(RegIntervalMs, 32'd1000);
    test_directed();
    test_count_saturation();
    // Restart low slots with interval zero treated as one.
    test_random(12, 32'd0, 2'd3);
    test_random(12, 32'd50, 2'd1);
    test_random(12, 32'd3, 2'd2);
    test_random(12, 32'hFFFF_FFFF, 2'd0);

    repeat (100) @(posedge clk);
    if (errors == 0 && pixel_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/aqhcm_pkg.sv
rtl/aqhcm_ctrl.sv
rtl/aqhcm_datapath.sv
rtl/air_quality_history_colour_mapper.sv
dv/tb_air_quality_history_colour_mapper.sv
